// ----- hdl/xbmd_pkg.sv -----
// ----------------------------------------------------------------------------
// xbmd_pkg: shared types and constants of the branch and memory-reference
// decoder.
// ----------------------------------------------------------------------------
package xbmd_pkg;

  localparam int CodeBytes = 16;
  localparam logic [4:0] RegNone = 5'd16;

  // instruction classes
  localparam logic [3:0] TypeUnknown  = 4'd0;
  localparam logic [3:0] TypeCallReg  = 4'd1;
  localparam logic [3:0] TypeCallInd  = 4'd2;
  localparam logic [3:0] TypeJmpReg   = 4'd3;
  localparam logic [3:0] TypeJmpInd   = 4'd4;
  localparam logic [3:0] TypePushMem  = 4'd5;
  localparam logic [3:0] TypePushReg  = 4'd6;
  localparam logic [3:0] TypeRet      = 4'd7;
  localparam logic [3:0] TypeAdd      = 4'd8;
  localparam logic [3:0] TypeSub      = 4'd9;
  localparam logic [3:0] TypeJcc      = 4'd10;
  localparam logic [3:0] TypeCallRel  = 4'd11;
  localparam logic [3:0] TypeJmpRel   = 4'd12;
  localparam logic [3:0] TypeMovMem   = 4'd13;
  localparam logic [3:0] TypeLea      = 4'd14;
  localparam logic [3:0] TypeMovImm   = 4'd15;

  // prefix scan result
  typedef struct packed {
    logic [3:0] off;     // opcode position
    logic       has_rex;
    logic [3:0] rex;
  } pfx_t;

  // decoded word before target add
  typedef struct packed {
    logic        ok;
    logic [3:0]  itype;
    logic [4:0]  len;
    logic [4:0]  dest;
    logic [4:0]  src;
    logic        mem;
    logic        rip;
    logic        rel;      // target = addr + len + disp
    logic        abs;      // target = sign-extended disp
    logic [31:0] disp;
    logic [63:0] imm;
  } dec_t;

endpackage

// ----- hdl/xbmd_decode.sv -----
// ----------------------------------------------------------------------------
// xbmd_decode: opcode, ModRM and SIB decode from a shifted byte window.
// ----------------------------------------------------------------------------
module xbmd_decode (
  input  logic [8*xbmd_pkg::CodeBytes-1:0] win_i,     // window from opcode on
  input  logic [3:0]                       off_i,     // opcode position
  input  logic                             has_rex_i,
  input  logic [3:0]                       rex_i,
  input  logic                             long_mode_i,
  input  logic [4:0]                       limit_i,
  output xbmd_pkg::dec_t                   dec_o
);
  import xbmd_pkg::*;

  function automatic logic [7:0] bt(input logic [8*CodeBytes-1:0] w, input int i);
    bt = (i < CodeBytes) ? w[8*i +: 8] : 8'h00;
  endfunction

  function automatic logic [31:0] rd32(input logic [8*CodeBytes-1:0] w, input int p);
    rd32 = {bt(w, p+3), bt(w, p+2), bt(w, p+1), bt(w, p)};
  endfunction

  // bytes are relative to the opcode; absolute position = off + index
  always_comb begin
    dec_t        d;
    logic [7:0]  op, m, sib, op2;
    logic [1:0]  mod;
    logic [2:0]  reg_f, rm;
    logic [4:0]  rexb, rexr;
    logic [4:0]  pos;     // relative length consumed
    logic [4:0]  mlen;
    logic [31:0] mdisp;
    logic        mmem, mrip, ok, use_modrm;
    int          dp;
    d = '0;
    d.dest = RegNone;
    d.src  = RegNone;
    op  = bt(win_i, 0);
    m   = bt(win_i, 1);
    sib = bt(win_i, 2);
    op2 = bt(win_i, 1);
    mod = m[7:6];
    reg_f = m[5:3];
    rm  = m[2:0];
    rexb = (has_rex_i && rex_i[0]) ? 5'd8 : 5'd0;
    rexr = (has_rex_i && rex_i[2]) ? 5'd8 : 5'd0;
    // ModRM length and displacement at relative position 1
    mlen = 5'd1;
    mdisp = '0;
    mmem = 1'b0;
    mrip = 1'b0;
    if (rm == 3'd4 && mod != 2'd3) begin
      mlen = 5'd2;
      if (sib[2:0] == 3'd5 && mod == 2'd0) mlen = 5'd6;
    end
    dp = 1 + int'(mlen);
    if (mod == 2'd0) begin
      if (rm == 3'd5) begin
        mdisp = rd32(win_i, dp);
        mmem = 1'b1;
        mrip = long_mode_i;
        mlen = mlen + 5'd4;
      end
    end else if (mod == 2'd1) begin
      mdisp = 32'($signed(bt(win_i, dp)));
      mmem = 1'b1;
      mlen = mlen + 5'd1;
    end else if (mod == 2'd2) begin
      mdisp = rd32(win_i, dp);
      mmem = 1'b1;
      mlen = mlen + 5'd4;
    end
    ok = 1'b1;
    use_modrm = 1'b0;
    pos = 5'd1;
    if (op == 8'hFF) begin
      if (reg_f == 3'd2 || reg_f == 3'd4 || reg_f == 3'd6) begin
        if (mod == 2'd3) begin
          d.itype = (reg_f == 3'd2) ? TypeCallReg :
                    (reg_f == 3'd4) ? TypeJmpReg : TypePushReg;
          d.src = {2'b00, rm} + rexb;
          pos = 5'd2;
        end else begin
          d.itype = (reg_f == 3'd2) ? TypeCallInd :
                    (reg_f == 3'd4) ? TypeJmpInd : TypePushMem;
          use_modrm = 1'b1;
        end
      end else ok = 1'b0;
    end else if (op == 8'hC3 || op == 8'hC2) begin
      d.itype = TypeRet;
      pos = (op == 8'hC2) ? 5'd3 : 5'd1;
    end else if (op[7:3] == 5'b01010) begin
      d.itype = TypePushReg;
      d.src = {2'b00, op[2:0]} + rexb;
    end else if (op == 8'h83 || op == 8'h81) begin
      if (reg_f == 3'd0) d.itype = TypeAdd;
      else if (reg_f == 3'd5) d.itype = TypeSub;
      else ok = 1'b0;
      d.dest = {2'b00, rm} + rexb;
      if (op == 8'h83) begin
        d.imm = 64'($signed(bt(win_i, 2)));
        pos = 5'd3;
      end else begin
        d.imm = 64'($signed(rd32(win_i, 2)));
        pos = 5'd6;
      end
    end else if (op[7:4] == 4'h7) begin
      d.itype = TypeJcc;
      d.disp = 32'($signed(bt(win_i, 1)));
      d.rel = 1'b1;
      pos = 5'd2;
    end else if (op == 8'h0F) begin
      if (op2[7:4] == 4'h8) begin
        d.itype = TypeJcc;
        d.disp = rd32(win_i, 2);
        d.rel = 1'b1;
        pos = 5'd6;
      end else ok = 1'b0;
    end else if (op == 8'hE8 || op == 8'hE9) begin
      d.itype = (op == 8'hE8) ? TypeCallRel : TypeJmpRel;
      d.disp = rd32(win_i, 1);
      d.rel = 1'b1;
      pos = 5'd5;
    end else if (op == 8'h8B) begin
      if (mod == 2'd3) ok = 1'b0;
      d.itype = TypeMovMem;
      d.dest = {2'b00, reg_f} + rexr;
      use_modrm = 1'b1;
    end else if (op == 8'h8D) begin
      d.itype = TypeLea;
      d.dest = {2'b00, reg_f} + rexr;
      use_modrm = 1'b1;
    end else if (op == 8'hA1) begin
      if (long_mode_i) ok = 1'b0;
      d.itype = TypeMovMem;
      d.mem = 1'b1;
      d.disp = rd32(win_i, 1);
      d.dest = 5'd0;
      pos = 5'd5;
    end else if (op[7:3] == 5'b10111) begin
      d.itype = TypeMovImm;
      d.dest = {2'b00, op[2:0]} + rexb;
      if (long_mode_i && has_rex_i && rex_i[3]) begin
        d.imm = {rd32(win_i, 5), rd32(win_i, 1)};
        pos = 5'd9;
      end else begin
        d.imm = 64'($signed(rd32(win_i, 1)));
        pos = 5'd5;
      end
    end else begin
      ok = 1'b0;
    end
    if (use_modrm) begin
      pos = 5'd1 + mlen;
      d.mem = mmem;
      d.rip = mrip;
      d.disp = mdisp;
    end
    d.len = {1'b0, off_i} + pos;
    if (d.len > limit_i) ok = 1'b0;
    if (d.mem) begin
      if (d.rip) d.rel = 1'b1;
      else if (!long_mode_i) d.abs = 1'b1;
    end
    if (!ok) begin
      d = '0;
      d.dest = RegNone;
      d.src  = RegNone;
    end
    d.ok = ok;
    dec_o = d;
  end

endmodule

// ----- hdl/x86_branch_and_memref_decoder.sv -----
// ----------------------------------------------------------------------------
// x86_branch_and_memref_decoder: decodes one x86 instruction per code window.
//
// Input channel s_axis: tdata carries code_low, code_high and instr_addr.
// Output channel m_axis: tdata carries the decoded fields, one word per
// input word. cfg: one-bit long_mode register, to be written by the user
// only while idle; the block does not enforce this. Pipeline of four
// register stages: input register, prefix scan, opcode shift with
// ModRM/SIB decode, target add. One word per cycle is accepted when the
// receiver takes words.
// A stall on m_axis holds every stage; s_axis_tready drops only when the
// last stage holds a word that cannot move. Reset clears all valid bits
// and long_mode; no word is lost or repeated across a stall.
// ----------------------------------------------------------------------------
module x86_branch_and_memref_decoder #(
  parameter int WINDOW_BYTES = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // code_low [63:0], code_high [127:64], instr_addr [191:128]
  input  logic [191:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // valid_res[0] instr_type[4:1] length[9:5] dest_reg[14:10] src_reg[19:15]
  // has_memory[20] rip_relative[21] displacement[53:22] immediate[117:54]
  // target_address[181:118], zeros [183:182]
  output logic [183:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [0:0]   cfg_data_i
);
  import xbmd_pkg::*;

  localparam logic [4:0] Limit = (WINDOW_BYTES < CodeBytes) ?
                                 5'(WINDOW_BYTES) : 5'(CodeBytes);

  logic long_mode_q;
  logic adv;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      long_mode_q <= cfg_data_i[0];
    end
  end

  // stage 1: input register
  logic         v1_q;
  logic [127:0] code1_q;
  logic [63:0]  addr1_q;
  // stage 2: prefix scan
  logic         v2_q;
  logic [127:0] code2_q;
  logic [63:0]  addr2_q;
  pfx_t         pfx2_q;
  pfx_t         pfx_d;
  // stage 3: decode
  logic         v3_q;
  logic [63:0]  addr3_q;
  dec_t         dec3_q;
  dec_t         dec_d;
  logic [127:0] shifted;
  // stage 4: output
  logic         v4_q;
  dec_t         dec4_q;
  logic [63:0]  tgt4_q;

  // prefix scan over up to 15 bytes
  always_comb begin
    logic stop;
    stop = 1'b0;
    pfx_d = '0;
    for (int i = 0; i < 15; i++) begin
      if (!stop) begin
        if (code1_q[8*i +: 8] == 8'h66 || code1_q[8*i +: 8] == 8'h67) begin
          pfx_d.off = 4'(i + 1);
        end else if (long_mode_q && code1_q[8*i+4 +: 4] == 4'h4) begin
          pfx_d.off = 4'(i + 1);
          pfx_d.has_rex = 1'b1;
          pfx_d.rex = code1_q[8*i +: 4];
        end else begin
          stop = 1'b1;
        end
      end
    end
  end

  assign shifted = code2_q >> {pfx2_q.off, 3'b000};

  xbmd_decode u_dec (
    .win_i      (shifted),
    .off_i      (pfx2_q.off),
    .has_rex_i  (pfx2_q.has_rex),
    .rex_i      (pfx2_q.rex),
    .long_mode_i(long_mode_q),
    .limit_i    (Limit),
    .dec_o      (dec_d)
  );

  // pipeline registers, all advance together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      code1_q <= s_axis_tdata[127:0];
      addr1_q <= s_axis_tdata[191:128];
      code2_q <= code1_q;
      addr2_q <= addr1_q;
      pfx2_q  <= pfx_d;
      addr3_q <= addr2_q;
      dec3_q  <= dec_d;
      dec4_q  <= dec3_q;
      if (dec3_q.rel) begin
        tgt4_q <= addr3_q + 64'(dec3_q.len) + {{32{dec3_q.disp[31]}}, dec3_q.disp};
      end else if (dec3_q.abs) begin
        tgt4_q <= {{32{dec3_q.disp[31]}}, dec3_q.disp};
      end else begin
        tgt4_q <= '0;
      end
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata = {2'b00, tgt4_q, dec4_q.imm, dec4_q.disp, dec4_q.rip, dec4_q.mem,
                         dec4_q.src, dec4_q.dest, dec4_q.len, dec4_q.itype, dec4_q.ok};

endmodule

// ----- hdl/xbmd_checker.sv -----
// ----------------------------------------------------------------------------
// xbmd_checker: port-level checks of the decoder.
// ----------------------------------------------------------------------------
module xbmd_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [183:0] m_axis_tdata
);

  // stalled output word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed under stall");

  // invalid result carries zero length
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[9:5] == 5'd0)
    else $error("invalid word with length");

  // valid result has nonzero length
  a_vlen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[9:5] != 5'd0)
    else $error("valid word with zero length");

  // accepted word reaches the output when no stall holds the stages
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
    |=> m_axis_tvalid)
    else $error("word lost in pipeline");

endmodule

bind x86_branch_and_memref_decoder xbmd_checker u_xbmd_checker (.*);
